### design/hkre_pkg.sv
// ============================================================================
// hkre_pkg: shared types and constants for the host key encoder
// Word layouts, configuration register indexes, reset values and the
// character codes used by the key translation.
// ============================================================================
package hkre_pkg;

    // Field widths
    localparam int HOST_CODE_W = 10;
    localparam int RETRO_W     = 7;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ARROW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ARROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_KEY  = 3'd4;

    // Configuration reset values
    localparam logic [HOST_CODE_W-1:0] RST_LEFT_ARROW  = 10'd314;
    localparam logic [HOST_CODE_W-1:0] RST_RIGHT_ARROW = 10'd316;
    localparam logic [HOST_CODE_W-1:0] RST_TAB         = 10'd9;
    localparam logic [HOST_CODE_W-1:0] RST_DELETE      = 10'd127;
    localparam logic [HOST_CODE_W-1:0] RST_REPEAT_KEY  = 10'd349;

    // Host code limits
    localparam logic [HOST_CODE_W-1:0] HOST_TYPABLE_END = 10'h07F;

    // Retro codes sent for special keys
    localparam logic [RETRO_W-1:0] RETRO_LEFT     = 7'd8;
    localparam logic [RETRO_W-1:0] RETRO_RIGHT    = 7'd21;
    localparam logic [RETRO_W-1:0] RETRO_CTRL_RBR = 7'd29;
    localparam logic [RETRO_W-1:0] CASE_OFFSET    = 7'd32;
    localparam logic [RETRO_W-1:0] CTRL_OFFSET    = 7'd64;

    // ASCII characters
    localparam logic [RETRO_W-1:0] CH_SPACE     = 7'h20;
    localparam logic [RETRO_W-1:0] CH_BANG      = 7'h21;
    localparam logic [RETRO_W-1:0] CH_DQUOTE    = 7'h22;
    localparam logic [RETRO_W-1:0] CH_HASH      = 7'h23;
    localparam logic [RETRO_W-1:0] CH_DOLLAR    = 7'h24;
    localparam logic [RETRO_W-1:0] CH_PERCENT   = 7'h25;
    localparam logic [RETRO_W-1:0] CH_AMP       = 7'h26;
    localparam logic [RETRO_W-1:0] CH_QUOTE     = 7'h27;
    localparam logic [RETRO_W-1:0] CH_LPAREN    = 7'h28;
    localparam logic [RETRO_W-1:0] CH_RPAREN    = 7'h29;
    localparam logic [RETRO_W-1:0] CH_STAR      = 7'h2A;
    localparam logic [RETRO_W-1:0] CH_PLUS      = 7'h2B;
    localparam logic [RETRO_W-1:0] CH_COMMA     = 7'h2C;
    localparam logic [RETRO_W-1:0] CH_MINUS     = 7'h2D;
    localparam logic [RETRO_W-1:0] CH_PERIOD    = 7'h2E;
    localparam logic [RETRO_W-1:0] CH_SLASH     = 7'h2F;
    localparam logic [RETRO_W-1:0] CH_0         = 7'h30;
    localparam logic [RETRO_W-1:0] CH_1         = 7'h31;
    localparam logic [RETRO_W-1:0] CH_2         = 7'h32;
    localparam logic [RETRO_W-1:0] CH_3         = 7'h33;
    localparam logic [RETRO_W-1:0] CH_4         = 7'h34;
    localparam logic [RETRO_W-1:0] CH_5         = 7'h35;
    localparam logic [RETRO_W-1:0] CH_6         = 7'h36;
    localparam logic [RETRO_W-1:0] CH_7         = 7'h37;
    localparam logic [RETRO_W-1:0] CH_8         = 7'h38;
    localparam logic [RETRO_W-1:0] CH_9         = 7'h39;
    localparam logic [RETRO_W-1:0] CH_COLON     = 7'h3A;
    localparam logic [RETRO_W-1:0] CH_SEMI      = 7'h3B;
    localparam logic [RETRO_W-1:0] CH_LT        = 7'h3C;
    localparam logic [RETRO_W-1:0] CH_EQUAL     = 7'h3D;
    localparam logic [RETRO_W-1:0] CH_GT        = 7'h3E;
    localparam logic [RETRO_W-1:0] CH_QUESTION  = 7'h3F;
    localparam logic [RETRO_W-1:0] CH_AT        = 7'h40;
    localparam logic [RETRO_W-1:0] CH_UPPER_A   = 7'h41;
    localparam logic [RETRO_W-1:0] CH_UPPER_M   = 7'h4D;
    localparam logic [RETRO_W-1:0] CH_UPPER_N   = 7'h4E;
    localparam logic [RETRO_W-1:0] CH_UPPER_P   = 7'h50;
    localparam logic [RETRO_W-1:0] CH_UPPER_Z   = 7'h5A;
    localparam logic [RETRO_W-1:0] CH_LBRACKET  = 7'h5B;
    localparam logic [RETRO_W-1:0] CH_BACKSLASH = 7'h5C;
    localparam logic [RETRO_W-1:0] CH_RBRACKET  = 7'h5D;
    localparam logic [RETRO_W-1:0] CH_CARET     = 7'h5E;
    localparam logic [RETRO_W-1:0] CH_UNDERSCORE = 7'h5F;
    localparam logic [RETRO_W-1:0] CH_BACKTICK  = 7'h60;
    localparam logic [RETRO_W-1:0] CH_LOWER_A   = 7'h61;
    localparam logic [RETRO_W-1:0] CH_LOWER_Z   = 7'h7A;
    localparam logic [RETRO_W-1:0] CH_TILDE     = 7'h7E;
    localparam logic [RETRO_W-1:0] CH_NUL       = 7'h00;

    // Input word: one host key event
    typedef struct packed {
        logic                   mode;
        logic [HOST_CODE_W-1:0] host_code;
        logic                   shift_held;
        logic                   control_held;
        logic                   auto_repeat;
    } hkre_in_t;

    // Output word: one result per event
    typedef struct packed {
        logic               code_valid;
        logic [RETRO_W-1:0] retro_code;
        logic               repeat_press;
        logic               repeat_release;
        logic               repeat_clear;
    } hkre_out_t;

    // Configuration register set
    typedef struct packed {
        logic [HOST_CODE_W-1:0] left_arrow_code;
        logic [HOST_CODE_W-1:0] right_arrow_code;
        logic [HOST_CODE_W-1:0] tab_code;
        logic [HOST_CODE_W-1:0] delete_code;
        logic [HOST_CODE_W-1:0] repeat_key_code;
    } hkre_cfg_t;

    // Translator status handed to the top level
    typedef struct packed {
        logic               accepted;
        logic [RETRO_W-1:0] code;
        logic               counted;
    } hkre_enc_t;

    // Shifted character for digits, punctuation and the letters M, N and P; others keep k
    function automatic logic [RETRO_W-1:0] shift_map(
        input logic [RETRO_W-1:0] c7,
        input logic [RETRO_W-1:0] k
    );
        logic [RETRO_W-1:0] r;
        case (c7)
            CH_BACKTICK: r = CH_TILDE;
            CH_1:        r = CH_BANG;
            CH_2:        r = CH_AT;
            CH_3:        r = CH_HASH;
            CH_4:        r = CH_DOLLAR;
            CH_5:        r = CH_PERCENT;
            CH_6:        r = CH_CARET;
            CH_7:        r = CH_AMP;
            CH_8:        r = CH_STAR;
            CH_9:        r = CH_LPAREN;
            CH_0:        r = CH_RPAREN;
            CH_MINUS:    r = CH_UNDERSCORE;
            CH_EQUAL:    r = CH_PLUS;
            CH_SEMI:     r = CH_COLON;
            CH_QUOTE:    r = CH_DQUOTE;
            CH_COMMA:    r = CH_LT;
            CH_PERIOD:   r = CH_GT;
            CH_SLASH:    r = CH_QUESTION;
            CH_UPPER_M:  r = CH_RBRACKET;
            CH_UPPER_N:  r = CH_CARET;
            CH_UPPER_P:  r = CH_AT;
            default:     r = k;
        endcase
        return r;
    endfunction

endpackage

### design/hkre_encode.sv
// ============================================================================
// hkre_encode: host key code translator
// Turns a host key code and its modifiers into a 7-bit retro keyboard
// code, flags rejected keys and tells whether the key counts as held.
// ============================================================================
module hkre_encode
    import hkre_pkg::*;
(
    input  hkre_cfg_t              cfg,
    input  logic [HOST_CODE_W-1:0] host_code,
    input  logic                   shift_held,
    input  logic                   control_held,
    output hkre_enc_t              enc
);

    logic               c_ascii;
    logic [RETRO_W-1:0] c7;
    logic               is_left;
    logic               is_right;
    logic               is_banned;
    logic               is_rbracket;
    logic               is_space;
    logic               is_digit;
    logic [RETRO_W-1:0] k_base;
    logic [RETRO_W-1:0] k_shift;
    logic [RETRO_W-1:0] k_ctrl;
    logic               ctrl_target;

    // Decode the host code
    assign c_ascii     = (host_code[HOST_CODE_W-1:RETRO_W] == '0);
    assign c7          = host_code[RETRO_W-1:0];
    assign is_left     = (host_code == cfg.left_arrow_code);
    assign is_right    = (host_code == cfg.right_arrow_code);
    assign is_rbracket = c_ascii && (c7 == CH_RBRACKET);
    assign is_space    = c_ascii && (c7 == CH_SPACE);
    assign is_digit    = c_ascii && (c7 >= CH_0) && (c7 <= CH_9);
    assign is_banned   = (host_code == cfg.tab_code) || (host_code == cfg.delete_code) ||
                         (c_ascii && ((c7 == CH_BACKTICK) || (c7 == CH_LBRACKET) ||
                                      (c7 == CH_BACKSLASH)));

    // Fold lower case, apply shift, then control
    always_comb
    begin
        k_base = c7;
        if ((c7 >= CH_LOWER_A) && (c7 <= CH_LOWER_Z))
        begin
            k_base = c7 - CASE_OFFSET;
        end
        k_shift = (shift_held && c_ascii) ? shift_map(c7, k_base) : k_base;
        ctrl_target = ((k_shift >= CH_UPPER_A) && (k_shift <= CH_UPPER_Z)) ||
                      (k_shift == CH_RBRACKET) || (k_shift == CH_CARET) ||
                      (k_shift == CH_AT);
        k_ctrl = (control_held && ctrl_target) ? (k_shift - CTRL_OFFSET) : k_shift;
    end

    // Pick the final code and decide acceptance
    always_comb
    begin
        enc.accepted = 1'b1;
        enc.code     = k_ctrl;
        if (is_left)
        begin
            enc.code = RETRO_LEFT;
        end
        else if (is_right)
        begin
            enc.code = RETRO_RIGHT;
        end
        else if (host_code[HOST_CODE_W-1:RETRO_W+1] != '0)
        begin
            enc.accepted = 1'b0;
        end
        else if (shift_held && control_held && is_space)
        begin
            enc.code = CH_SPACE;
        end
        else if (control_held && !shift_held &&
                 (is_digit || is_space || (c_ascii && (c7 == CH_SLASH))))
        begin
            enc.code = c7;
        end
        else if (is_rbracket)
        begin
            if (shift_held)
            begin
                enc.accepted = 1'b0;
            end
            else if (control_held)
            begin
                enc.code = RETRO_CTRL_RBR;
            end
        end
        else if ((k_ctrl == CH_NUL) || is_banned)
        begin
            enc.accepted = 1'b0;
        end

        // Held-key counting uses its own typable rule
        enc.counted = ((host_code < HOST_TYPABLE_END) || is_left || is_right) &&
                      !is_banned && !(is_rbracket && shift_held);
    end

endmodule

### design/host_key_to_retro_ascii_encoder.sv
// ============================================================================
// host_key_to_retro_ascii_encoder: host key event to retro keyboard code
// Translates key events, tracks the held-key count and flags the repeat key.
// ============================================================================
// Takes one key event word per cycle while in_stall is low and returns
// exactly one result word per event from the output register. An input
// register captures the event, and the translator and the held-key counter
// update sit between it and the output register. The input register
// advances only when the output register can take its word, so a new
// event is taken every cycle while results keep moving; while a finished
// result is stalled at the output, one more event waits in the input
// register and then the input stalls. The held-key count (0 to 255) is
// updated as each event moves into the output register. Configuration
// writes are taken at any time through the write port and must only be
// issued while no event is in flight.
module host_key_to_retro_ascii_encoder
    import hkre_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  hkre_in_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output hkre_out_t              out_word,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [HOST_CODE_W-1:0] cfg_wdata
);

    hkre_cfg_t          cfg_reg;
    hkre_in_t           s1_word_reg;
    logic               s1_valid_reg;
    hkre_out_t          out_word_reg;
    hkre_out_t          out_word_next;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] held_count_reg;
    logic [COUNT_W-1:0] held_count_next;
    hkre_enc_t          enc;
    logic               out_move;
    logic               s1_move;
    logic               is_repeat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_arrow_code  <= RST_LEFT_ARROW;
            cfg_reg.right_arrow_code <= RST_RIGHT_ARROW;
            cfg_reg.tab_code         <= RST_TAB;
            cfg_reg.delete_code      <= RST_DELETE;
            cfg_reg.repeat_key_code  <= RST_REPEAT_KEY;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LEFT_ARROW:  cfg_reg.left_arrow_code  <= cfg_wdata;
                CFG_RIGHT_ARROW: cfg_reg.right_arrow_code <= cfg_wdata;
                CFG_TAB:         cfg_reg.tab_code         <= cfg_wdata;
                CFG_DELETE:      cfg_reg.delete_code      <= cfg_wdata;
                CFG_REPEAT_KEY:  cfg_reg.repeat_key_code  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Stage handshake
    assign out_move = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_move;
    assign in_stall = s1_valid_reg && !out_move;

    // Hold the accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_word_reg <= in_word;
        end
    end

    // Translate the held event
    hkre_encode u_encode (
        .cfg          (cfg_reg),
        .host_code    (s1_word_reg.host_code),
        .shift_held   (s1_word_reg.shift_held),
        .control_held (s1_word_reg.control_held),
        .enc          (enc)
    );

    assign is_repeat = (s1_word_reg.host_code == cfg_reg.repeat_key_code);

    // Build the result and the next held count
    always_comb
    begin
        out_word_next   = '0;
        held_count_next = held_count_reg;
        if (!s1_word_reg.mode)
        begin
            if (!s1_word_reg.auto_repeat)
            begin
                if (enc.counted && (held_count_reg != '1))
                begin
                    held_count_next = held_count_reg + 1'b1;
                end
                if (is_repeat)
                begin
                    out_word_next.repeat_press = 1'b1;
                end
                else if (enc.accepted)
                begin
                    out_word_next.code_valid = 1'b1;
                    out_word_next.retro_code = enc.code;
                end
            end
        end
        else
        begin
            if (enc.counted)
            begin
                if (held_count_reg != '0)
                begin
                    held_count_next = held_count_reg - 1'b1;
                end
                out_word_next.repeat_clear = (held_count_next == '0);
            end
            out_word_next.repeat_release = is_repeat;
        end
    end

    // Advance the count and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_move)
            begin
                held_count_reg <= held_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A result never carries both a translated code and a repeat press
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_word_reg.code_valid && out_word_reg.repeat_press))
        else $error("code_valid and repeat_press both set");

    // A clear request leaves the count at zero until the next event moves
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.repeat_clear) |-> (held_count_reg == '0))
        else $error("repeat_clear with nonzero held count");

    // The count only changes when an event moves to the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(held_count_reg))
        else $error("held count changed without an event");

    // Press results never carry release-side flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_word_reg.code_valid || out_word_reg.repeat_press)) |->
        !(out_word_reg.repeat_release || out_word_reg.repeat_clear))
        else $error("press result carries release flags");

endmodule

### sim/tb_host_key_to_retro_ascii_encoder.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_host_key_to_retro_ascii_encoder: self-checking bench for the key encoder
// Walks a table of hand-picked key events, then runs phases of random press
// and release sequences under several key maps and idling patterns. Each
// event word is predicted in the bench, and every result word is compared
// field by field with the oldest pending expected word.
// ============================================================================
module tb_host_key_to_retro_ascii_encoder;
    import hkre_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 8;
    localparam int DOWN_KEYS_MAX  = 64;

    localparam logic KEY_PRESS   = 1'b0;
    localparam logic KEY_RELEASE = 1'b1;

    localparam hkre_out_t QUIET = '0;

    // One row of the directed table: event, and a typed-in result if any
    typedef struct packed {
        hkre_in_t  ev;
        logic      has_literal;
        hkre_out_t literal;
    } key_vector_t;

    // Flags are {shift, control, auto_repeat}
    key_vector_t directed_rows [25] = '{
        // release with nothing held: count stays at zero, clear is raised
        '{ {KEY_RELEASE, {3'b000, CH_UPPER_A}, 3'b000}, 1'b1, {1'b0, CH_NUL, 3'b001} },
        '{ {KEY_PRESS, {3'b000, CH_LOWER_A}, 3'b000}, 1'b1, {1'b1, CH_UPPER_A, 3'b000} },
        '{ {KEY_PRESS, RST_LEFT_ARROW, 3'b110}, 1'b1, {1'b1, RETRO_LEFT, 3'b000} },
        '{ {KEY_PRESS, RST_RIGHT_ARROW, 3'b000}, 1'b1, {1'b1, RETRO_RIGHT, 3'b000} },
        '{ {KEY_PRESS, RST_REPEAT_KEY, 3'b000}, 1'b1, {1'b0, CH_NUL, 3'b100} },
        '{ {KEY_RELEASE, RST_REPEAT_KEY, 3'b000}, 1'b1, {1'b0, CH_NUL, 3'b010} },
        // shifted close bracket is rejected and not counted
        '{ {KEY_PRESS, {3'b000, CH_RBRACKET}, 3'b100}, 1'b1, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_RBRACKET}, 3'b010}, 1'b1, {1'b1, RETRO_CTRL_RBR, 3'b000} },
        '{ {KEY_PRESS, RST_TAB, 3'b000}, 1'b1, QUIET },
        '{ {KEY_PRESS, RST_DELETE, 3'b000}, 1'b1, QUIET },
        '{ {KEY_PRESS, 10'h3FF, 3'b110}, 1'b1, QUIET },
        // host auto-repeat press is dropped entirely
        '{ {KEY_PRESS, {3'b000, CH_LOWER_Z}, 3'b001}, 1'b1, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_NUL}, 3'b000}, 1'b0, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_2}, 3'b100}, 1'b0, QUIET },
        '{ {KEY_PRESS, 10'h070, 3'b010}, 1'b0, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_UPPER_P}, 3'b110}, 1'b0, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_SPACE}, 3'b110}, 1'b0, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_5}, 3'b010}, 1'b0, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_SLASH}, 3'b010}, 1'b0, QUIET },
        '{ {KEY_PRESS, 10'h0E1, 3'b010}, 1'b0, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_BACKTICK}, 3'b100}, 1'b0, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_UPPER_M}, 3'b100}, 1'b0, QUIET },
        '{ {KEY_PRESS, {3'b000, CH_UPPER_N}, 3'b110}, 1'b0, QUIET },
        '{ {KEY_RELEASE, {3'b000, CH_UPPER_A}, 3'b001}, 1'b0, QUIET },
        '{ {KEY_RELEASE, {3'b000, CH_RBRACKET}, 3'b100}, 1'b0, QUIET }
    };

    // Random phases: length, share of presses, letters-only flag
    int phase_items [NUM_PHASES] = '{200, 200, 350, 350, 150, 150, 125, 125};
    int phase_press [NUM_PHASES] = '{60, 55, 95, 5, 60, 50, 60, 55};
    bit phase_letters [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    hkre_in_t               in_word;
    logic                   out_valid;
    logic                   out_stall;
    hkre_out_t              out_word;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [HOST_CODE_W-1:0] cfg_wdata;

    // Bench copy of the key map and the held-key counter
    hkre_cfg_t          key_map;
    logic [COUNT_W-1:0] held_total;

    hkre_out_t pending_codes [$];
    hkre_in_t  down_keys [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int mismatches     = 0;
    int events_sent    = 0;
    int results_checked = 0;
    int map_writes     = 0;
    int peak_held      = 0;
    int full_hits      = 0;
    int clear_flags    = 0;

    host_key_to_retro_ascii_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // True when a host code is exactly the given 7-bit character
    function automatic logic code_is(input logic [HOST_CODE_W-1:0] c,
                                     input logic [RETRO_W-1:0] ch);
        return c == {3'b000, ch};
    endfunction

    // Keys that take part in the held-key count
    function automatic logic is_held_key(input logic [HOST_CODE_W-1:0] c, input logic sh);
        logic typable;
        logic banned;
        typable = c < HOST_TYPABLE_END || c == key_map.left_arrow_code ||
                  c == key_map.right_arrow_code;
        banned  = c == key_map.tab_code || code_is(c, CH_BACKTICK) ||
                  code_is(c, CH_LBRACKET) || code_is(c, CH_BACKSLASH) ||
                  c == key_map.delete_code;
        return typable && !banned && !(code_is(c, CH_RBRACKET) && sh);
    endfunction

    // Predict the result word of one event and advance the held count
    function automatic hkre_out_t predict_key_result(input hkre_in_t ev);
        hkre_out_t               res;
        logic [HOST_CODE_W-1:0]  c;
        logic [RETRO_W-1:0]      k;
        logic                    ok;
        logic                    counted;
        logic                    sh;
        logic                    ct;
        res     = QUIET;
        c       = ev.host_code;
        sh      = ev.shift_held;
        ct      = ev.control_held;
        counted = is_held_key(c, sh);
        if (ev.mode == KEY_PRESS)
        begin
            if (!ev.auto_repeat)
            begin
                if (counted)
                begin
                    if (held_total == '1)
                        full_hits++;
                    else
                        held_total++;
                    if (held_total > peak_held)
                        peak_held = held_total;
                end
                if (c == key_map.repeat_key_code)
                begin
                    res.repeat_press = 1'b1;
                end
                else
                begin
                    ok = 1'b1;
                    k  = c[RETRO_W-1:0];
                    if (c == key_map.left_arrow_code)
                        k = RETRO_LEFT;
                    else if (c == key_map.right_arrow_code)
                        k = RETRO_RIGHT;
                    else if (c[HOST_CODE_W-1:8] != '0)
                        ok = 1'b0;
                    else
                    begin
                        // fold lower case, then apply shift on the raw code
                        if (k >= CH_LOWER_A && k <= CH_LOWER_Z)
                            k = k - CASE_OFFSET;
                        if (sh && c[7] == 1'b0)
                        begin
                            case (c[RETRO_W-1:0])
                                CH_BACKTICK: k = CH_TILDE;
                                CH_1:        k = CH_BANG;
                                CH_2:        k = CH_AT;
                                CH_3:        k = CH_HASH;
                                CH_4:        k = CH_DOLLAR;
                                CH_5:        k = CH_PERCENT;
                                CH_6:        k = CH_CARET;
                                CH_7:        k = CH_AMP;
                                CH_8:        k = CH_STAR;
                                CH_9:        k = CH_LPAREN;
                                CH_0:        k = CH_RPAREN;
                                CH_MINUS:    k = CH_UNDERSCORE;
                                CH_EQUAL:    k = CH_PLUS;
                                CH_SEMI:     k = CH_COLON;
                                CH_QUOTE:    k = CH_DQUOTE;
                                CH_COMMA:    k = CH_LT;
                                CH_PERIOD:   k = CH_GT;
                                CH_SLASH:    k = CH_QUESTION;
                                CH_UPPER_M:  k = CH_RBRACKET;
                                CH_UPPER_N:  k = CH_CARET;
                                CH_UPPER_P:  k = CH_AT;
                                default:     k = k;
                            endcase
                        end
                        if (ct && ((k >= CH_UPPER_A && k <= CH_UPPER_Z) ||
                                   k == CH_RBRACKET || k == CH_CARET || k == CH_AT))
                            k = k - CTRL_OFFSET;
                        // special cases, checked in order
                        if (sh && ct && code_is(c, CH_SPACE))
                            k = CH_SPACE;
                        else if (ct && !sh && ((c >= {3'b000, CH_0} && c <= {3'b000, CH_9}) ||
                                 code_is(c, CH_SLASH) || code_is(c, CH_SPACE)))
                            k = c[RETRO_W-1:0];
                        else if (code_is(c, CH_RBRACKET))
                        begin
                            if (sh)
                                ok = 1'b0;
                            else if (ct)
                                k = RETRO_CTRL_RBR;
                        end
                        else if (k == CH_NUL || c == key_map.tab_code ||
                                 code_is(c, CH_BACKTICK) || code_is(c, CH_LBRACKET) ||
                                 code_is(c, CH_BACKSLASH) || c == key_map.delete_code)
                            ok = 1'b0;
                    end
                    res.code_valid = ok;
                    res.retro_code = ok ? k : CH_NUL;
                end
            end
        end
        else
        begin
            if (counted)
            begin
                if (held_total != '0)
                    held_total--;
                if (held_total == '0)
                begin
                    res.repeat_clear = 1'b1;
                    clear_flags++;
                end
            end
            if (c == key_map.repeat_key_code)
                res.repeat_release = 1'b1;
        end
        return res;
    endfunction

    // Host code mix: printable, control, mapped keys, specials, high codes
    function automatic logic [HOST_CODE_W-1:0] random_host_code();
        int sel;
        logic [HOST_CODE_W-1:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            c = HOST_CODE_W'($urandom_range(32, 126));
        else if (sel < 50)
            c = HOST_CODE_W'($urandom_range(0, 31));
        else if (sel < 62)
        begin
            case ($urandom_range(0, 4))
                0:       c = key_map.left_arrow_code;
                1:       c = key_map.right_arrow_code;
                2:       c = key_map.tab_code;
                3:       c = key_map.delete_code;
                default: c = key_map.repeat_key_code;
            endcase
        end
        else if (sel < 72)
        begin
            case ($urandom_range(0, 8))
                0:       c = {3'b000, CH_BACKTICK};
                1:       c = {3'b000, CH_LBRACKET};
                2:       c = {3'b000, CH_BACKSLASH};
                3:       c = {3'b000, CH_RBRACKET};
                4:       c = {3'b000, CH_UPPER_M};
                5:       c = {3'b000, CH_UPPER_N};
                6:       c = {3'b000, CH_UPPER_P};
                7:       c = {3'b000, CH_SPACE};
                default: c = {3'b000, CH_SLASH};
            endcase
        end
        else if (sel < 80)
            c = HOST_CODE_W'($urandom_range(128, 255));
        else if (sel < 90)
            c = HOST_CODE_W'($urandom_range(256, 1023));
        else
            c = HOST_CODE_W'($urandom());
        return c;
    endfunction

    // Build one event; releases mostly let go of a key that is down
    function automatic hkre_in_t random_key_event(input int press_pct, input bit letters);
        hkre_in_t ev;
        int       pick;
        ev.mode         = KEY_PRESS;
        ev.shift_held   = 1'($urandom_range(0, 1));
        ev.control_held = 1'($urandom_range(0, 1));
        ev.auto_repeat  = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 99) < press_pct)
        begin
            ev.host_code = letters ? HOST_CODE_W'($urandom_range(CH_LOWER_A, CH_LOWER_Z))
                                   : random_host_code();
            if (!ev.auto_repeat && down_keys.size() < DOWN_KEYS_MAX)
                down_keys.push_back(ev);
        end
        else
        begin
            ev.mode = KEY_RELEASE;
            if (down_keys.size() != 0 && $urandom_range(0, 9) < 8)
            begin
                pick = $urandom_range(0, down_keys.size() - 1);
                ev.host_code  = down_keys[pick].host_code;
                ev.shift_held = down_keys[pick].shift_held;
                down_keys.delete(pick);
            end
            else
                ev.host_code = letters ? HOST_CODE_W'($urandom_range(CH_LOWER_A, CH_LOWER_Z))
                                       : random_host_code();
        end
        return ev;
    endfunction

    function automatic logic [HOST_CODE_W-1:0] random_map_code();
        return $urandom_range(0, 1) ? HOST_CODE_W'($urandom_range(0, 127))
                                    : HOST_CODE_W'($urandom_range(0, 1023));
    endfunction

    // Offer one event word, hold it until taken, then predict its result
    task automatic send_key_event(input hkre_in_t ev, input logic has_literal,
                                  input hkre_out_t literal);
        hkre_out_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_key_result(ev);
        pending_codes.push_back(has_literal ? literal : predicted);
        events_sent++;
    endtask

    // Write one register; the caller drops the enable after the last one
    task automatic write_map_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [HOST_CODE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic apply_key_map(input hkre_cfg_t m);
        write_map_reg(CFG_LEFT_ARROW, m.left_arrow_code);
        write_map_reg(CFG_RIGHT_ARROW, m.right_arrow_code);
        write_map_reg(CFG_TAB, m.tab_code);
        write_map_reg(CFG_DELETE, m.delete_code);
        write_map_reg(CFG_REPEAT_KEY, m.repeat_key_code);
        cfg_wr_en <= 1'b0;
        key_map = m;
        map_writes++;
    endtask

    task automatic wait_for_drain(input int extra);
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    // Check each taken result word and randomize the output stall
    always @(posedge clk)
    begin
        hkre_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("result word %h with no event pending", out_word);
                mismatches++;
            end
            else
            begin
                want = pending_codes.pop_front();
                results_checked++;
                if (out_word.code_valid !== want.code_valid)
                begin
                    $error("code_valid: expected %0b, got %0b",
                           want.code_valid, out_word.code_valid);
                    mismatches++;
                end
                if (out_word.retro_code !== want.retro_code)
                begin
                    $error("retro_code: expected %0d, got %0d",
                           want.retro_code, out_word.retro_code);
                    mismatches++;
                end
                if (out_word.repeat_press !== want.repeat_press)
                begin
                    $error("repeat_press: expected %0b, got %0b",
                           want.repeat_press, out_word.repeat_press);
                    mismatches++;
                end
                if (out_word.repeat_release !== want.repeat_release)
                begin
                    $error("repeat_release: expected %0b, got %0b",
                           want.repeat_release, out_word.repeat_release);
                    mismatches++;
                end
                if (out_word.repeat_clear !== want.repeat_clear)
                begin
                    $error("repeat_clear: expected %0b, got %0b",
                           want.repeat_clear, out_word.repeat_clear);
                    mismatches++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog: end the run after too long without any word moving
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        hkre_cfg_t new_map;
        hkre_in_t  ev;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        out_stall  = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        held_total = '0;
        key_map    = '{left_arrow_code: RST_LEFT_ARROW, right_arrow_code: RST_RIGHT_ARROW,
                       tab_code: RST_TAB, delete_code: RST_DELETE,
                       repeat_key_code: RST_REPEAT_KEY};
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table on the reset key map
        foreach (directed_rows[i])
            send_key_event(directed_rows[i].ev, directed_rows[i].has_literal,
                           directed_rows[i].literal);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Change the key map only with nothing in flight
            if (p != 0)
            begin
                wait_for_drain(4);
                case (p)
                    1:
                        new_map = '{left_arrow_code: '0, right_arrow_code: '1,
                                    tab_code: '0, delete_code: '1, repeat_key_code: '0};
                    2:
                        new_map = '{left_arrow_code: {3'b000, CH_LOWER_A},
                                    right_arrow_code: {3'b000, CH_LOWER_A},
                                    tab_code: {3'b000, CH_RBRACKET},
                                    delete_code: {3'b000, CH_TILDE},
                                    repeat_key_code: 10'h3FE};
                    NUM_PHASES - 1:
                        new_map = '{left_arrow_code: RST_LEFT_ARROW,
                                    right_arrow_code: RST_RIGHT_ARROW,
                                    tab_code: RST_TAB, delete_code: RST_DELETE,
                                    repeat_key_code: RST_REPEAT_KEY};
                    default:
                    begin
                        new_map.left_arrow_code  = random_map_code();
                        new_map.right_arrow_code = random_map_code();
                        new_map.tab_code         = random_map_code();
                        new_map.delete_code      = random_map_code();
                        new_map.repeat_key_code  = random_map_code();
                    end
                endcase
                apply_key_map(new_map);
            end

            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase

            for (int n = 0; n < phase_items[p]; n++)
            begin
                ev = random_key_event(phase_press[p], phase_letters[p]);
                send_key_event(ev, 1'b0, QUIET);
            end
            in_valid <= 1'b0;
        end

        wait_for_drain(SETTLE_CYCLES);

        $display("ran %0d key events through %0d phases and %0d key map writes, %0d results checked",
                 events_sent, NUM_PHASES, map_writes, results_checked);
        $display("held count peaked at %0d, pinned at full %0d times, clear raised %0d times",
                 peak_held, full_hits, clear_flags);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
design/hkre_pkg.sv
design/hkre_encode.sv
design/host_key_to_retro_ascii_encoder.sv
sim/tb_host_key_to_retro_ascii_encoder.sv
